[src/dids_pkg.sv]
// Shared types and constants for the display idle dim/sleep policy unit.
// Holds phase and mode codes, register indexes and the ctrl/datapath interface structs.
// No dependencies.
package dids_pkg;

    typedef enum logic [1:0]
    {
        PH_ACTIVE = 2'd0,
        PH_DIM    = 2'd1,
        PH_SLEEP  = 2'd2
    } phase_t;

    typedef enum logic [1:0]
    {
        MODE_KEY    = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_FOLLOW = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    // register index = paddr[4:2]
    localparam logic [2:0] REG_DIM_AFTER   = 3'd0;
    localparam logic [2:0] REG_SLEEP_AFTER = 3'd1;
    localparam logic [2:0] REG_FADE_LENGTH = 3'd2;
    localparam logic [2:0] REG_ACTIVE_LVL  = 3'd3;
    localparam logic [2:0] REG_DIM_LVL     = 3'd4;

    localparam int unsigned DIV_STEPS = 8;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_APPLY,
        ST_LEVEL,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed
    {
        logic [31:0] dim_after_ms;
        logic [31:0] sleep_after_ms;
        logic [15:0] fade_length_ms;
        logic [7:0]  active_level;
        logic [7:0]  dim_level;
    } cfg_t;

    typedef struct packed
    {
        logic capture;   // latch the incoming request
        logic apply;     // update policy state
        logic level;     // compute elapsed, product and direct level
        logic div_step;  // one restoring divide step
        logic load_out;  // load the output register
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic need_div;  // dim phase still fading
    } dp_status_t;

endpackage

[src/dids_ctrl.sv]
// Controller FSM for the display idle dim/sleep policy unit.
// Sequences capture, state update, level compute, divide and output load.
// Depends on dids_pkg.
module dids_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  dids_pkg::dp_status_t   status,
    output dids_pkg::ctrl_cmd_t    cmd
);
    import dids_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_LEVEL;
            ST_LEVEL:  state_next = status.need_div ? ST_DIVIDE : ST_FINISH;
            ST_DIVIDE: if (cnt_reg == CNT_LAST) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_APPLY:  cmd.apply = 1'b1;
            ST_LEVEL:
            begin
                cmd.level = 1'b1;
                cnt_next  = '0;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
            end
            ST_FINISH: cmd.load_out = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

[src/dids_datapath.sv]
// Datapath for the display idle dim/sleep policy unit.
// Policy state, fade product, 8-step restoring divider and output register.
// Depends on dids_pkg.
module dids_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dids_pkg::cfg_t         cfg,
    input  dids_pkg::ctrl_cmd_t    cmd,
    output dids_pkg::dp_status_t   status,
    input  logic [1:0]             in_mode,
    input  logic [31:0]            in_now_ms,
    input  logic [7:0]             in_requested_phase,
    output logic [1:0]             out_phase,
    output logic [7:0]             out_brightness
);
    import dids_pkg::*;

    // request
    mode_t       mode_reg;
    logic [31:0] now_reg;
    logic [7:0]  req_reg;

    // policy state
    logic [31:0] last_key_reg, last_key_next;
    logic [31:0] phase_start_reg, phase_start_next;
    phase_t      phase_reg, phase_next;
    logic        started_reg, started_next;

    // level / divide
    logic [23:0] wrk_reg;
    logic [7:0]  direct_reg;
    logic        use_div_reg;
    logic [1:0]  out_phase_reg;
    logic [7:0]  out_bright_reg;

    logic [31:0] lk0, ps0, idle_age, elapsed;
    phase_t      ph0, target;
    logic        fading;
    logic [7:0]  span, direct;
    logic [24:0] shifted;
    logic [16:0] trial_hi, sub_hi;
    logic        ge;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode_t'(in_mode);
            now_reg  <= in_now_ms;
            req_reg  <= in_requested_phase;
        end
    end

    // effective state after the start-up init
    always_comb
    begin
        if (!started_reg && mode_reg != MODE_QUERY)
        begin
            lk0 = now_reg;
            ps0 = now_reg;
            ph0 = PH_ACTIVE;
        end
        else
        begin
            lk0 = last_key_reg;
            ps0 = phase_start_reg;
            ph0 = phase_reg;
        end
        idle_age = now_reg - lk0;
    end

    always_comb
    begin
        target = PH_ACTIVE;
        case (mode_reg)
            MODE_UPDATE:
            begin
                if (idle_age >= cfg.sleep_after_ms)
                    target = PH_SLEEP;
                else if (idle_age >= cfg.dim_after_ms)
                    target = PH_DIM;
                else
                    target = PH_ACTIVE;
            end
            MODE_FOLLOW:
                target = (req_reg > 8'(PH_SLEEP)) ? PH_ACTIVE : phase_t'(req_reg[1:0]);
            default: target = PH_ACTIVE;
        endcase
    end

    always_comb
    begin
        last_key_next    = last_key_reg;
        phase_start_next = phase_start_reg;
        phase_next       = phase_reg;
        started_next     = started_reg;
        if (cmd.apply)
        begin
            case (mode_reg)
                MODE_KEY:
                begin
                    last_key_next    = now_reg;
                    phase_start_next = now_reg;
                    phase_next       = PH_ACTIVE;
                    started_next     = 1'b1;
                end
                MODE_UPDATE, MODE_FOLLOW:
                begin
                    phase_start_next = (target != ph0) ? now_reg : ps0;
                    phase_next       = target;
                    started_next     = 1'b1;
                    if (mode_reg == MODE_FOLLOW && target == PH_ACTIVE)
                        last_key_next = now_reg;
                    else
                        last_key_next = lk0;
                end
                default: started_next = started_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg    <= '0;
            phase_start_reg <= '0;
            phase_reg       <= PH_ACTIVE;
            started_reg     <= 1'b0;
        end
        else
        begin
            last_key_reg    <= last_key_next;
            phase_start_reg <= phase_start_next;
            phase_reg       <= phase_next;
            started_reg     <= started_next;
        end
    end

    // level from the updated state
    assign elapsed = now_reg - phase_start_reg;
    assign fading  = started_reg && phase_reg == PH_DIM
                     && elapsed < {16'd0, cfg.fade_length_ms};
    assign span    = (cfg.active_level >= cfg.dim_level) ?
                     (cfg.active_level - cfg.dim_level) : 8'd0;

    always_comb
    begin
        if (!started_reg || phase_reg == PH_ACTIVE)
            direct = cfg.active_level;
        else if (phase_reg == PH_SLEEP)
            direct = 8'd0;
        else
            direct = cfg.dim_level;
    end

    assign status.need_div = fading;

    // restoring divide; product < 256*fade keeps the quotient in 8 bits
    assign shifted  = {wrk_reg, 1'b0};
    assign trial_hi = shifted[24:8];
    assign ge       = trial_hi >= {1'b0, cfg.fade_length_ms};
    assign sub_hi   = trial_hi - {1'b0, cfg.fade_length_ms};

    always_ff @(posedge clk)
    begin
        if (cmd.level)
        begin
            wrk_reg     <= {16'd0, span} * {8'd0, elapsed[15:0]};
            direct_reg  <= direct;
            use_div_reg <= fading;
        end
        else if (cmd.div_step)
        begin
            wrk_reg <= {(ge ? sub_hi[15:0] : trial_hi[15:0]), wrk_reg[6:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_phase_reg  <= phase_reg;
            out_bright_reg <= use_div_reg ? (cfg.active_level - wrk_reg[7:0]) : direct_reg;
        end
    end

    assign out_phase      = out_phase_reg;
    assign out_brightness = out_bright_reg;

endmodule

[src/display_idle_dim_sleep_policy_unit.sv]
// Top level of the display idle dim/sleep policy unit.
// Config registers and APB port; instantiates dids_ctrl and dids_datapath.
// Depends on dids_pkg.
//
//  channel   dir   handshake              payload
//  s_axis    in    s_tvalid / s_tready    mode, now_ms, requested_phase
//  m_axis    out   m_tvalid / m_tready    current_phase_out, brightness
//  apb       in    psel/penable/pready    5 config registers, 4-byte stride
//
// Each request passes through accept, state update, level and output load,
// plus the divide steps when the dim fade is active; the one-bit-per-cycle
// restoring divider scales the fade. A new request is accepted only once
// the unit is back in idle. Reset is asynchronous and clears the policy
// state and handshake flags; config resets to its documented defaults.
// The result sits in an output register, so a new request is taken while
// the previous result waits; a stall on m_axis holds the unit in its last
// step until the output register is free.
module display_idle_dim_sleep_policy_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [1:0] mode, [33:2] now_ms, [41:34] requested_phase
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] current_phase_out, [9:2] brightness
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dids_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    ctrl_cmd_t   cmd;
    dp_status_t  status;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    logic [1:0]  out_phase;
    logic [7:0]  out_bright;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // register write decode; indexes past the list are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DIM_AFTER:   cfg_next.dim_after_ms   = pwdata;
                REG_SLEEP_AFTER: cfg_next.sleep_after_ms = pwdata;
                REG_FADE_LENGTH: cfg_next.fade_length_ms = pwdata[15:0];
                REG_ACTIVE_LVL:  cfg_next.active_level   = pwdata[7:0];
                REG_DIM_LVL:     cfg_next.dim_level      = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_after_ms   <= 32'd30000;
            cfg_reg.sleep_after_ms <= 32'd120000;
            cfg_reg.fade_length_ms <= 16'd1000;
            cfg_reg.active_level   <= 8'd255;
            cfg_reg.dim_level      <= 8'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_DIM_AFTER:   prdata = cfg_reg.dim_after_ms;
            REG_SLEEP_AFTER: prdata = cfg_reg.sleep_after_ms;
            REG_FADE_LENGTH: prdata = {16'd0, cfg_reg.fade_length_ms};
            REG_ACTIVE_LVL:  prdata = {24'd0, cfg_reg.active_level};
            REG_DIM_LVL:     prdata = {24'd0, cfg_reg.dim_level};
            default:         prdata = 32'd0;
        endcase
    end

    dids_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dids_datapath u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .cmd                (cmd),
        .status             (status),
        .in_mode            (s_tdata[1:0]),
        .in_now_ms          (s_tdata[33:2]),
        .in_requested_phase (s_tdata[41:34]),
        .out_phase          (out_phase),
        .out_brightness     (out_bright)
    );

    // s_tdata[47:42] is padding
    assign m_tdata = {6'd0, out_bright, out_phase};

    // one request in flight: no accept in the cycle after an accept
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("illegal phase on output");

    a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == PH_SLEEP) |-> (m_tdata[9:2] == 8'd0))
        else $error("sleep phase with nonzero brightness");

    a_active_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == PH_ACTIVE) |-> (m_tdata[9:2] == cfg_reg.active_level))
        else $error("active phase brightness mismatch");

endmodule

[verif/dids_policy_checker.sv]
// Checker for the display idle dim/sleep policy unit: watches the request, result and
// APB channels, keeps its own copy of the policy and compares every result in order.
// Depends on dids_pkg.
module dids_policy_checker
    import dids_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [1:0] mode, [33:2] now_ms, [41:34] requested_phase
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [1:0] current_phase_out, [9:2] brightness
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          outstanding,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct
    {
        phase_t     phase;
        logic [7:0] level;
    } phase_level_t;

    phase_level_t phase_level_q[$];
    phase_level_t oldest;
    phase_level_t fresh;

    // register copy
    logic [31:0] dim_after;
    logic [31:0] sleep_after;
    logic [15:0] fade_len;
    logic [7:0]  lvl_active;
    logic [7:0]  lvl_dim;

    // policy copy
    logic [31:0] key_stamp;
    logic [31:0] phase_stamp;
    phase_t      phase;
    logic        running;

    function automatic logic [7:0] level_for(input logic [31:0] now);
        logic [31:0] elapsed;
        logic [31:0] span;
        logic [31:0] drop;
        elapsed = now - phase_stamp;
        span = (lvl_active >= lvl_dim) ? 32'(lvl_active - lvl_dim) : 32'd0;
        if (!running || phase == PH_ACTIVE)
            return lvl_active;
        if (phase == PH_SLEEP)
            return 8'd0;
        if (elapsed >= 32'(fade_len))
            return lvl_dim;
        // elapsed < fade_len here, so the divisor is nonzero
        drop = (span * elapsed) / 32'(fade_len);
        return lvl_active - drop[7:0];
    endfunction

    task automatic apply_request(input mode_t m, input logic [31:0] now, input logic [7:0] req);
        logic [31:0] idle;
        phase_t      nxt;
        if (m != MODE_QUERY && !running)
        begin
            key_stamp   = now;
            phase_stamp = now;
            phase       = PH_ACTIVE;
            running     = 1'b1;
        end
        case (m)
            MODE_KEY:
            begin
                key_stamp   = now;
                phase_stamp = now;
                phase       = PH_ACTIVE;
            end
            MODE_UPDATE, MODE_FOLLOW:
            begin
                idle = now - key_stamp;
                if (m == MODE_FOLLOW)
                    nxt = (req > 8'(PH_SLEEP)) ? PH_ACTIVE : phase_t'(req[1:0]);
                else if (idle >= sleep_after)
                    nxt = PH_SLEEP;
                else if (idle >= dim_after)
                    nxt = PH_DIM;
                else
                    nxt = PH_ACTIVE;
                if (nxt != phase)
                    phase_stamp = now;
                phase = nxt;
                if (m == MODE_FOLLOW && nxt == PH_ACTIVE)
                    key_stamp = now;
            end
            default: ;
        endcase
        fresh.phase = phase;
        fresh.level = level_for(now);
        phase_level_q.push_back(fresh);
    endtask

    // Sampled on the falling edge: every handshake signal is settled there and holds
    // the values that the next rising edge takes.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_after   = 32'd30000;
            sleep_after = 32'd120000;
            fade_len    = 16'd1000;
            lvl_active  = 8'd255;
            lvl_dim     = 8'd64;
            key_stamp   = '0;
            phase_stamp = '0;
            phase       = PH_ACTIVE;
            running     = 1'b0;
            fail_count  = 0;
            phase_level_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_DIM_AFTER:   dim_after   = pwdata;
                    REG_SLEEP_AFTER: sleep_after = pwdata;
                    REG_FADE_LENGTH: fade_len    = pwdata[15:0];
                    REG_ACTIVE_LVL:  lvl_active  = pwdata[7:0];
                    REG_DIM_LVL:     lvl_dim     = pwdata[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (phase_level_q.size() == 0)
                begin
                    $error("result with no request pending: m_tdata %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    oldest = phase_level_q.pop_front();
                    if (m_tdata[1:0] !== oldest.phase)
                    begin
                        $error("current_phase_out mismatch: expected %0d, actual %0d",
                               oldest.phase, m_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_tdata[9:2] !== oldest.level)
                    begin
                        $error("brightness mismatch: expected %0d, actual %0d",
                               oldest.level, m_tdata[9:2]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_request(mode_t'(s_tdata[1:0]), s_tdata[33:2], s_tdata[41:34]);
            outstanding <= phase_level_q.size();
        end
    end

endmodule

[verif/display_idle_dim_sleep_policy_unit_tb.sv]
// Testbench top for the display idle dim/sleep policy unit: clock, reset, request and
// APB stimulus, result back-pressure and the verdict.
// Depends on dids_pkg, display_idle_dim_sleep_policy_unit and dids_policy_checker.
module display_idle_dim_sleep_policy_unit_tb;
    import dids_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Slowest request: the block's longest path plus the longest send gap and result stall;
    // ~540 requests plus register writes stay far below this.
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [1:0] mode, [33:2] now_ms, [41:34] requested_phase
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [1:0] current_phase_out, [9:2] brightness
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          outstanding;
    int          fail_total;
    int          cycle_count = 0;

    logic [31:0] t_ms     = '0;   // running millisecond clock for the requests
    int          step_max = 60;   // largest forward step of t_ms per request
    bit          calm     = 1'b0; // set for the final stretch: no idling on either side

    display_idle_dim_sleep_policy_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dids_policy_checker policy_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .outstanding (outstanding),
        .fail_count  (fail_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts between ready stretches.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(posedge clk);
        end
    end

    // One request. tvalid is left high after the handshake so back-to-back requests
    // never lower and raise it in the same step; stop_sending drops it before any wait.
    // s_tready is looked at on the falling edge, where it is settled, and the task
    // returns just after the rising edge that takes the request.
    task automatic send_request(input mode_t m, input logic [31:0] now, input logic [7:0] rp);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tdata  <= {6'd0, rp, now, m};
        s_tvalid <= 1'b1;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // Quiesce: no request in flight and every result back, then a margin longer than
    // the unit's worst-case request so the unit is truly idle.
    task automatic settle();
        stop_sending();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // APB write: setup phase, access phase, then back to idle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [31:0] dim_ms, input logic [31:0] sleep_ms,
                                  input logic [15:0] fade, input logic [7:0] hi_lvl,
                                  input logic [7:0] lo_lvl);
        write_reg(REG_DIM_AFTER, dim_ms);
        write_reg(REG_SLEEP_AFTER, sleep_ms);
        write_reg(REG_FADE_LENGTH, {16'd0, fade});
        write_reg(REG_ACTIVE_LVL, {24'd0, hi_lvl});
        write_reg(REG_DIM_LVL, {24'd0, lo_lvl});
    endtask

    // Mostly small thresholds so dim and sleep are reached within a few requests.
    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(1, 500);
        endcase
    endfunction

    task automatic load_random_settings();
        logic [31:0] dim_ms;
        logic [31:0] sleep_ms;
        logic [15:0] fade;
        logic [7:0]  hi_lvl;
        logic [7:0]  lo_lvl;
        logic [7:0]  swap;
        dim_ms   = pick_threshold();
        // usually sleep lies above dim; now and then the order is reversed or extreme
        sleep_ms = ($urandom_range(0, 3) == 0) ? pick_threshold()
                                              : dim_ms + $urandom_range(1, 500);
        case ($urandom_range(0, 7))
            0:       fade = 16'd0;
            1:       fade = 16'hFFFF;
            default: fade = 16'($urandom_range(1, 200));
        endcase
        hi_lvl = ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom);
        lo_lvl = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
        // mostly a legal setup (active >= dim); inverted levels stay as a corner case
        if ($urandom_range(0, 4) != 0 && hi_lvl < lo_lvl)
        begin
            swap   = hi_lvl;
            hi_lvl = lo_lvl;
            lo_lvl = swap;
        end
        write_settings(dim_ms, sleep_ms, fade, hi_lvl, lo_lvl);
        step_max = $urandom_range(20, 120);
        // sometimes restart the clock just short of the 32-bit wrap
        if ($urandom_range(0, 2) == 0)
            t_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    endtask

    // Random requests: time mostly creeps forward so updates walk through
    // active, dim and sleep; occasional jumps and repeated stamps are noise.
    task automatic random_burst(input int count);
        int         pick;
        logic [7:0] rp;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19))
                0:       t_ms = $urandom;
                1:       ;
                default: t_ms = t_ms + $urandom_range(1, step_max);
            endcase
            rp   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_request(MODE_KEY, t_ms, rp);
            else if (pick < 60)
                send_request(MODE_UPDATE, t_ms, rp);
            else if (pick < 75)
                send_request(MODE_FOLLOW, t_ms, rp);
            else
                send_request(MODE_QUERY, t_ms, rp);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: dim 30000, sleep 120000, fade 1000, levels 255/64.
        send_request(MODE_QUERY, 32'hFFFF_FFFF, 8'hFF);           // query before start
        send_request(MODE_UPDATE, 32'hFFFF_FF00, 8'h00);          // first update starts it
        send_request(MODE_UPDATE, 32'hFFFF_FF00 + 32'd29999, 8'h00);
        send_request(MODE_UPDATE, 32'hFFFF_FF00 + 32'd30000, 8'h00); // now wraps past zero
        send_request(MODE_QUERY, 32'hFFFF_FF00 + 32'd30500, 8'h00);  // mid fade
        send_request(MODE_QUERY, 32'hFFFF_FF00 + 32'd31000, 8'h00);  // fade complete
        send_request(MODE_UPDATE, 32'hFFFF_FF00 + 32'd120000, 8'h00); // sleep
        send_request(MODE_KEY, 32'd200000, 8'h00);
        send_request(MODE_FOLLOW, 32'd200005, 8'd1);
        send_request(MODE_FOLLOW, 32'd200006, 8'd2);
        send_request(MODE_FOLLOW, 32'd200007, 8'd3);              // unknown phase -> active
        send_request(MODE_FOLLOW, 32'd200008, 8'hFF);
        send_request(MODE_KEY, 32'hFFFF_FFFF, 8'h00);

        // Sleep threshold below dim, zero fade, active level below dim level.
        settle();
        write_settings(32'hFFFF_FFFF, 32'd100, 16'd0, 8'd10, 8'd200);
        send_request(MODE_KEY, 32'd1000, 8'h00);
        send_request(MODE_UPDATE, 32'd1099, 8'h00);
        send_request(MODE_UPDATE, 32'd1100, 8'h00);               // sleep wins over dim
        send_request(MODE_FOLLOW, 32'd1200, 8'd1);                // zero fade: dim level at once

        // Inverted levels with a real fade: active level until the fade ends.
        settle();
        write_settings(32'd0, 32'hFFFF_FFFF, 16'd50, 8'd10, 8'd200);
        send_request(MODE_KEY, 32'd2000, 8'h00);
        send_request(MODE_UPDATE, 32'd2000, 8'h00);
        send_request(MODE_UPDATE, 32'd2049, 8'h00);
        send_request(MODE_UPDATE, 32'd2050, 8'h00);

        // Longest fade over the full level swing.
        settle();
        write_settings(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'h00);
        send_request(MODE_KEY, 32'd3000, 8'h00);
        send_request(MODE_UPDATE, 32'd3000, 8'h00);
        send_request(MODE_QUERY, 32'd3000 + 32'd65534, 8'h00);
        send_request(MODE_QUERY, 32'd3000 + 32'd65535, 8'h00);

        // Random phases, each with fresh settings written while the unit is idle.
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            if (ph == 5)
                calm = 1'b1;
            load_random_settings();
            if (ph == 2)
            begin
                // hold off mid-phase until every result is back
                random_burst(40);
                settle();
                random_burst(45);
            end
            else
                random_burst(85);
        end

        settle();
        repeat (40) @(posedge clk);
        if (fail_total == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[display_idle_dim_sleep_policy_unit.f]
src/dids_pkg.sv
src/dids_ctrl.sv
src/dids_datapath.sv
src/display_idle_dim_sleep_policy_unit.sv
verif/dids_policy_checker.sv
verif/display_idle_dim_sleep_policy_unit_tb.sv
